FILE: src/swm_pkg.sv
// swm_pkg: shared constants and the cell control struct of the sliding window maximum unit
// no dependencies; used by swm_cell and sliding_window_maximum_unit
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_BITS        = 7;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic accept;   // an input transfer is taken this cycle
        logic restart;  // that transfer opens a new stream
        logic shift;    // front candidate leaves with the transfer
        logic drain;    // idle cycle, front candidate is stale
    } cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/swm_cell.sv
// swm_cell: one slot of the ordered candidate chain (value, age, valid)
// depends on swm_pkg for cell_ctl_t
`default_nettype none

module swm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int AW          = 7
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  swm_pkg::cell_ctl_t            ctl,
    input  wire signed [SAMPLE_BITS-1:0]  sample,
    input  wire                           prev_keep,
    output logic                          keep,
    input  wire                           next_cur_valid,
    input  wire signed [SAMPLE_BITS-1:0]  next_cur_value,
    input  wire        [AW-1:0]           next_cur_age,
    input  wire                           next_vn_valid,
    input  wire signed [SAMPLE_BITS-1:0]  next_vn_value,
    input  wire        [AW-1:0]           next_vn_age,
    output logic                          cur_valid,
    output logic signed [SAMPLE_BITS-1:0] cur_value,
    output logic       [AW-1:0]           cur_age,
    output logic                          vn_valid,
    output logic signed [SAMPLE_BITS-1:0] vn_value,
    output logic       [AW-1:0]           vn_age
);
    import swm_pkg::*;

    logic                          valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg, value_next;
    logic        [AW-1:0]          age_reg, age_next;
    logic                          new_here;

    // a candidate survives only while strictly above the new sample
    assign keep     = valid_reg && !ctl.restart && (value_reg > sample);
    assign new_here = !keep && prev_keep;

    assign vn_valid = keep || new_here;
    assign vn_value = keep ? value_reg : sample;
    assign vn_age   = keep ? (age_reg + 1'b1) : '0;

    assign cur_valid = valid_reg;
    assign cur_value = value_reg;
    assign cur_age   = age_reg;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        age_next   = age_reg;
        if (ctl.accept)
        begin
            if (ctl.shift)
            begin
                valid_next = next_vn_valid;
                value_next = next_vn_value;
                age_next   = next_vn_age;
            end
            else
            begin
                valid_next = vn_valid;
                value_next = vn_value;
                age_next   = vn_age;
            end
        end
        else if (ctl.drain)
        begin
            valid_next = next_cur_valid;
            value_next = next_cur_value;
            age_next   = next_cur_age;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        age_reg   <= age_next;
    end

endmodule

`default_nettype wire

FILE: src/sliding_window_maximum_unit.sv
// sliding_window_maximum_unit: top level, chain of swm_cell slots plus output register
// depends on swm_pkg and swm_cell
// result: registered in the output register, valid in the cycle after its input transfer
// throughput: one sample per cycle while results are taken; after the window is narrowed,
//   stale front candidates are drained first, while the next sample waits
// reset: all cell valid flags, fill count and output valid clear at once; width resets to 1
`default_nettype none

module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF,
    localparam int DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [swm_pkg::CFG_BITS-1:0] cfg_data,       // window_width
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [DATA_BITS-1:0]         s_axis_tdata,   // sample, zero padding
    input  wire  [0:0]                   s_axis_tuser,   // restart
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [DATA_BITS-1:0]         m_axis_tdata    // window_max, zero padding
);
    import swm_pkg::*;

    localparam int N  = WINDOW_MAX;
    localparam int AW = $clog2(WINDOW_MAX + 1);

    logic [CFG_BITS-1:0]           width_reg;
    logic [AW-1:0]                 w_eff;
    logic [AW-1:0]                 fill_reg, fill_next;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          restart;
    logic                          accept;
    logic                          stale0;
    logic                          emit;
    cell_ctl_t                     ctl;

    logic                          chain_keep [N+1];
    logic                          cur_valid  [N+1];
    logic signed [SAMPLE_BITS-1:0] cur_value  [N+1];
    logic        [AW-1:0]          cur_age    [N+1];
    logic                          vn_valid   [N+1];
    logic signed [SAMPLE_BITS-1:0] vn_value   [N+1];
    logic        [AW-1:0]          vn_age     [N+1];
    logic        [N-1:0]           valid_vec;

    assign cfg_ready = 1'b1;
    assign sample    = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign restart   = s_axis_tuser[0];

    always_comb
    begin
        if (width_reg == '0)
            w_eff = AW'(1);
        else if (int'(width_reg) > WINDOW_MAX)
            w_eff = AW'(WINDOW_MAX);
        else
            w_eff = AW'(width_reg);
    end

    // front candidate outside the window, only after a narrowing write
    assign stale0        = cur_valid[0] && (cur_age[0] >= w_eff);
    assign s_axis_tready = !stale0 && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // stale candidates go only once a sample is waiting, so the width it sees applies
    assign ctl = '{accept:  accept,
                   restart: restart,
                   shift:   vn_valid[0] && (vn_age[0] >= w_eff),
                   drain:   stale0 && s_axis_tvalid};

    // virtual slot past the end of the chain
    assign chain_keep[0] = 1'b1;
    assign cur_valid[N]  = 1'b0;
    assign cur_value[N]  = '0;
    assign cur_age[N]    = '0;
    assign vn_valid[N]   = chain_keep[N];
    assign vn_value[N]   = sample;
    assign vn_age[N]     = '0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .AW          (AW)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .sample         (sample),
            .prev_keep      (chain_keep[k]),
            .keep           (chain_keep[k+1]),
            .next_cur_valid (cur_valid[k+1]),
            .next_cur_value (cur_value[k+1]),
            .next_cur_age   (cur_age[k+1]),
            .next_vn_valid  (vn_valid[k+1]),
            .next_vn_value  (vn_value[k+1]),
            .next_vn_age    (vn_age[k+1]),
            .cur_valid      (cur_valid[k]),
            .cur_value      (cur_value[k]),
            .cur_age        (cur_age[k]),
            .vn_valid       (vn_valid[k]),
            .vn_value       (vn_value[k]),
            .vn_age         (vn_age[k])
        );
        assign valid_vec[k] = cur_valid[k];
    end

    always_comb
    begin
        if (restart)
            fill_next = AW'(1);
        else if (int'(fill_reg) < WINDOW_MAX)
            fill_next = fill_reg + 1'b1;
        else
            fill_next = fill_reg;
    end

    assign emit = fill_next >= w_eff;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        max_next       = max_reg;
        if (accept)
        begin
            out_valid_next = emit;
            max_next       = ctl.shift ? vn_value[1] : vn_value[0];
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_BITS'(1);
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                width_reg <= cfg_data;
            if (accept)
                fill_reg <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_BITS'($unsigned(max_reg));

    // after a transfer the front holds a candidate inside the window
    a_front_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (cur_valid[0] && !stale0))
        else $error("front candidate missing or stale after transfer");

    // occupied slots always form a run from the front
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + 1'b1)) == '0)
        else $error("gap in candidate chain");

    // the front candidate is strictly above the second candidate
    a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid[1] |-> (cur_value[0] > cur_value[1]))
        else $error("candidate order broken");

    // no transfer is taken while stale candidates are drained
    a_no_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
        stale0 |=> ($stable(fill_reg)))
        else $error("fill count moved during drain");

endmodule

`default_nettype wire
